// ===== hw/rtl/rfa_pkg.sv =====
`default_nettype none
package rfa_pkg;

   localparam int CFG_W     = 13;
   localparam int PAGE_W    = 12;
   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FREE   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DECREF = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_NO_MEMORY = 3'd1;
   localparam logic [STATUS_W-1:0] STS_REFERENCED = 3'd2;
   localparam logic [STATUS_W-1:0] STS_ALREADY   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd4;
   localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PAGES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PAGES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FREE  = 2'd2;

   localparam logic [CFG_W-1:0] TOTAL_PAGES_RST = 13'd4096;
   localparam logic [CFG_W-1:0] BASE_PAGES_RST  = 13'd160;
   localparam logic [CFG_W-1:0] FIRST_FREE_RST  = 13'd1024;

   typedef struct packed {
      logic       listed;
      logic       last;
   } walk_flags_type;

endpackage
`default_nettype wire

// ===== hw/rtl/rfa_ram.sv =====
`default_nettype none
module rfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rfa_init_walk.sv =====
`default_nettype none
module rfa_init_walk #(
   parameter int MAX_PAGES = 4096,
   localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
   localparam int NW = $clog2(MAX_PAGES + 1),
   localparam int CW = (NW > rfa_pkg::CFG_W) ? NW : rfa_pkg::CFG_W
) (
   input  wire logic                  clock,
   input  wire logic                  start,
   input  wire logic                  advance,
   input  wire logic [CW-1:0]         lim_b,
   input  wire logic [CW-1:0]         lim_f,
   input  wire logic [CW-1:0]         lim_t,
   output logic      [AW-1:0]         walk_page,
   output logic      [NW-1:0]         walk_next,
   output rfa_pkg::walk_flags_type    walk_flags
);
   import rfa_pkg::*;

   localparam logic [NW-1:0] NIL = NW'(MAX_PAGES);

   logic [AW-1:0] walk_ff, walk_in;
   logic [CW-1:0] i_ext, i_succ;
   logic          in_low, in_high;

   assign i_ext   = CW'(walk_ff);
   assign i_succ  = i_ext + CW'(1);
   assign in_low  = (i_ext >= CW'(1)) && (i_ext < lim_b);
   assign in_high = (i_ext >= lim_f) && (i_ext < lim_t);

   always_comb begin
      walk_next = NIL;
      if (in_low) begin
         if (i_succ < lim_b) begin
            walk_next = NW'(i_succ);
         end else if (lim_f < lim_t) begin
            walk_next = NW'(lim_f);
         end
      end else if (in_high) begin
         if (i_succ < lim_t) begin
            walk_next = NW'(i_succ);
         end
      end
   end

   assign walk_flags.listed = in_low || in_high;
   assign walk_flags.last   = (walk_ff == AW'(MAX_PAGES - 1));
   assign walk_page         = walk_ff;

   always_comb begin
      walk_in = walk_ff;
      if (start) begin
         walk_in = '0;
      end else if (advance && !walk_flags.last) begin
         walk_in = walk_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/refcounted_page_frame_allocator_core.sv =====
`default_nettype none
// channel  | direction | handshake          | payload
// req      | in        | req_valid/stall    | command, page_index, zero_fill
// rsp      | out       | rsp_valid/stall    | status, granted_page, is_allocated,
//          |           |                    | clear_request, page_freed
// csr      | in        | csr_valid/ready    | csr_index, csr_wdata
//
// Alloc, free, decref, query and unknown commands: the accept cycle issues the
// page-table RAM reads, and S_EXEC does the update once the response is free.
// Init walks the RAMs one page a cycle, from page 0 to MAX_PAGES - 1.
// Reset restores the CSRs and clears control state and list head/tail; the
// page stores are undefined until init writes them. A stalled response holds
// the block in its final cycle; a new request is taken while a response waits.
module refcounted_page_frame_allocator_core #(
   parameter int MAX_PAGES = 4096,
   parameter int REF_WIDTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [rfa_pkg::CMD_W-1:0]        req_command,
   input  wire logic [rfa_pkg::PAGE_W-1:0]       req_page_index,
   input  wire logic                             req_zero_fill,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [rfa_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [rfa_pkg::PAGE_W-1:0]       rsp_granted_page,
   output logic                                  rsp_is_allocated,
   output logic                                  rsp_clear_request,
   output logic                                  rsp_page_freed,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rfa_pkg::CFG_W-1:0]        csr_wdata
);
   import rfa_pkg::*;

   localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int NW = $clog2(MAX_PAGES + 1);
   localparam int CW = (NW > CFG_W) ? NW : CFG_W;
   localparam logic [NW-1:0] NIL  = NW'(MAX_PAGES);
   localparam logic [CW-1:0] MAXC = CW'(MAX_PAGES);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_INIT = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   granted;
      logic                is_allocated;
      logic                clear_request;
      logic                page_freed;
   } rsp_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0] cfg_total_ff, cfg_base_ff, cfg_first_ff;
   logic [CW-1:0]    lim_t_ff, lim_b_ff, lim_f_ff;
   logic [CW-1:0]    lim_t_in, lim_b_in, lim_f_in, ffp_clip;

   logic [CMD_W-1:0]  cmd_ff;
   logic [PAGE_W-1:0] page_ff;
   logic              zf_ff;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [NW-1:0]     head_ff, head_in, tail_ff, tail_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CW-1:0]     req_ext, page_ext;
   logic [NW-1:0]     page_nw;
   logic              accept, out_free, fire, in_range;

   logic [AW-1:0]        rd_addr, wr_addr;
   logic                 link_we, ref_we, lst_we;
   logic [NW-1:0]        link_wd, link_rd;
   logic [REF_WIDTH-1:0] ref_wd, ref_rd, ref_dec;
   logic [0:0]           lst_wd, lst_rd;

   logic [AW-1:0]        walk_page;
   logic [NW-1:0]        walk_next;
   walk_flags_type       walk_flags;
   logic                 walk_start;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_total_ff <= TOTAL_PAGES_RST;
         cfg_base_ff  <= BASE_PAGES_RST;
         cfg_first_ff <= FIRST_FREE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TOTAL_PAGES: cfg_total_ff <= csr_wdata;
            CSR_BASE_PAGES:  cfg_base_ff  <= csr_wdata;
            CSR_FIRST_FREE:  cfg_first_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      lim_t_in = (CW'(cfg_total_ff) < MAXC) ? CW'(cfg_total_ff) : MAXC;
      lim_b_in = (CW'(cfg_base_ff) < lim_t_in) ? CW'(cfg_base_ff) : lim_t_in;
      ffp_clip = (CW'(cfg_first_ff) < lim_t_in) ? CW'(cfg_first_ff) : lim_t_in;
      lim_f_in = (ffp_clip < lim_b_in) ? lim_b_in : ffp_clip;
   end

   always_ff @(posedge clock) begin
      lim_t_ff <= lim_t_in;
      lim_b_ff <= lim_b_in;
      lim_f_ff <= lim_f_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_ext  = CW'(req_page_index);
   assign page_ext = CW'(page_ff);
   assign page_nw  = NW'(page_ext);
   assign in_range = page_ext < lim_t_ff;
   assign ref_dec  = ref_rd - REF_WIDTH'(1);

   assign addr_in = (req_command == CMD_ALLOC) ? head_ff[AW-1:0] : req_ext[AW-1:0];
   assign rd_addr = (state_ff == S_IDLE) ? addr_in : addr_ff;
   assign wr_addr = (state_ff == S_INIT) ? walk_page : addr_ff;
   assign walk_start = accept && (req_command == CMD_INIT);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      fire     = 1'b0;
      rsp_in   = '0;
      link_we  = 1'b0;
      ref_we   = 1'b0;
      lst_we   = 1'b0;
      link_wd  = NIL;
      ref_wd   = ref_dec;
      lst_wd   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_command == CMD_INIT) ? S_INIT : S_EXEC;
            end
         end
         S_INIT: begin
            link_we = 1'b1;
            ref_we  = 1'b1;
            lst_we  = 1'b1;
            link_wd = walk_next;
            ref_wd  = walk_flags.listed ? '0 : REF_WIDTH'(1);
            lst_wd  = walk_flags.listed;
            if (walk_flags.last && out_free) begin
               fire     = 1'b1;
               state_in = S_IDLE;
               if (lim_b_ff > CW'(1)) begin
                  head_in = NW'(1);
               end else if (lim_f_ff < lim_t_ff) begin
                  head_in = NW'(lim_f_ff);
               end else begin
                  head_in = NIL;
               end
               if (lim_f_ff < lim_t_ff) begin
                  tail_in = NW'(lim_t_ff - CW'(1));
               end else if (lim_b_ff > CW'(1)) begin
                  tail_in = NW'(lim_b_ff - CW'(1));
               end else begin
                  tail_in = NIL;
               end
            end
         end
         S_EXEC: begin
            if (out_free) begin
               fire     = 1'b1;
               state_in = S_IDLE;
               case (cmd_ff)
                  CMD_ALLOC: begin
                     if (head_ff >= NIL) begin
                        rsp_in.status = STS_NO_MEMORY;
                     end else begin
                        head_in = link_rd;
                        if (link_rd == NIL) begin
                           tail_in = NIL;
                        end
                        link_we = 1'b1;
                        lst_we  = 1'b1;
                        rsp_in.granted       = PAGE_W'(head_ff);
                        rsp_in.clear_request = zf_ff;
                     end
                  end
                  CMD_FREE, CMD_DECREF: begin
                     if (!in_range) begin
                        rsp_in.status = STS_RANGE;
                     end else if ((cmd_ff == CMD_FREE) && (ref_rd != '0)) begin
                        rsp_in.status = STS_REFERENCED;
                     end else if ((cmd_ff == CMD_DECREF) && (ref_rd == '0)) begin
                        rsp_in.status = STS_UNDERFLOW;
                     end else begin
                        ref_we = (cmd_ff == CMD_DECREF);
                        if ((cmd_ff == CMD_FREE) || (ref_dec == '0)) begin
                           if (lst_rd[0]) begin
                              rsp_in.status = STS_ALREADY;
                           end else begin
                              link_we = 1'b1;
                              link_wd = head_ff;
                              lst_we  = 1'b1;
                              lst_wd  = 1'b1;
                              head_in = page_nw;
                              if (tail_ff == NIL) begin
                                 tail_in = page_nw;
                              end
                              rsp_in.page_freed = (cmd_ff == CMD_DECREF);
                           end
                        end
                     end
                  end
                  CMD_QUERY: begin
                     if (!in_range) begin
                        rsp_in.status = STS_RANGE;
                     end else begin
                        rsp_in.is_allocated = !lst_rd[0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         page_ff <= req_page_index;
         zf_ff   <= req_zero_fill;
         addr_ff <= addr_in;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   rfa_init_walk #(
      .MAX_PAGES(MAX_PAGES)
   ) u_walk (
      .clock      (clock),
      .start      (walk_start),
      .advance    (state_ff == S_INIT),
      .lim_b      (lim_b_ff),
      .lim_f      (lim_f_ff),
      .lim_t      (lim_t_ff),
      .walk_page  (walk_page),
      .walk_next  (walk_next),
      .walk_flags (walk_flags)
   );

   rfa_ram #(
      .WIDTH(NW),
      .DEPTH(MAX_PAGES)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (wr_addr),
      .wdata (link_wd),
      .raddr (rd_addr),
      .rdata (link_rd)
   );

   rfa_ram #(
      .WIDTH(REF_WIDTH),
      .DEPTH(MAX_PAGES)
   ) u_ref_ram (
      .clock (clock),
      .we    (ref_we),
      .waddr (wr_addr),
      .wdata (ref_wd),
      .raddr (rd_addr),
      .rdata (ref_rd)
   );

   rfa_ram #(
      .WIDTH(1),
      .DEPTH(MAX_PAGES)
   ) u_list_ram (
      .clock (clock),
      .we    (lst_we),
      .waddr (wr_addr),
      .wdata (lst_wd),
      .raddr (rd_addr),
      .rdata (lst_rd)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_granted_page  = rsp_ff.granted;
   assign rsp_is_allocated  = rsp_ff.is_allocated;
   assign rsp_clear_request = rsp_ff.clear_request;
   assign rsp_page_freed    = rsp_ff.page_freed;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
   import rfa_pkg::*;

   localparam int PAGE_SPAN = 4096;
   localparam int REF_BITS  = 16;
   localparam logic [CFG_W-1:0] NIL_PAGE = CFG_W'(PAGE_SPAN);
   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_QUERY + 1'b1;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;
   localparam int PAGE_MAX_IDX = (1 << PAGE_W) - 1;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [PAGE_W-1:0] page;
      logic              zf;
   } page_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   granted;
      logic                alloc;
      logic                clear;
      logic                freed;
   } frame_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_command = '0;
   logic [PAGE_W-1:0]    req_page_index = '0;
   logic                 req_zero_fill = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [PAGE_W-1:0]    rsp_granted_page;
   logic                 rsp_is_allocated;
   logic                 rsp_clear_request;
   logic                 rsp_page_freed;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   refcounted_page_frame_allocator_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_page_index    (req_page_index),
      .req_zero_fill     (req_zero_fill),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_granted_page  (rsp_granted_page),
      .rsp_is_allocated  (rsp_is_allocated),
      .rsp_clear_request (rsp_clear_request),
      .rsp_page_freed    (rsp_page_freed),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // allocator shadow state
   logic [CFG_W-1:0]    cfg_total = TOTAL_PAGES_RST;
   logic [CFG_W-1:0]    cfg_base  = BASE_PAGES_RST;
   logic [CFG_W-1:0]    cfg_first = FIRST_FREE_RST;
   logic [CFG_W-1:0]    link_tbl   [PAGE_SPAN];
   logic [REF_BITS-1:0] refs_tbl   [PAGE_SPAN];
   logic                listed_tbl [PAGE_SPAN];
   logic [CFG_W-1:0]    head_pg = NIL_PAGE;
   logic [CFG_W-1:0]    tail_pg = NIL_PAGE;
   logic [PAGE_W-1:0]   held_pages[$];

   page_request_type cmd_backlog[$];
   frame_reply_type  expected_replies[$];

   page_request_type cur_req = '0;
   bit req_busy = 1'b0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit gaps_on = 1'b1;
   bit hold_off_req = 1'b0;
   int req_gap = 0;
   int rsp_wait = 0;
   int hold_left = 0;

   int mismatch_count = 0;
   int requests_sent = 0;
   int replies_checked = 0;
   int rebuilds_seen = 0;
   int settings_used = 1;

   function automatic int unsigned managed_pages();
      return (cfg_total < PAGE_SPAN) ? cfg_total : PAGE_SPAN;
   endfunction

   function automatic logic [STATUS_W-1:0] push_free_page(input logic [PAGE_W-1:0] pg);
      if (refs_tbl[pg] != 0)
         return STS_REFERENCED;
      if (listed_tbl[pg])
         return STS_ALREADY;
      link_tbl[pg] = head_pg;
      listed_tbl[pg] = 1'b1;
      head_pg = {1'b0, pg};
      if (tail_pg == NIL_PAGE)
         tail_pg = {1'b0, pg};
      return STS_OK;
   endfunction

   function automatic frame_reply_type predict_frame_reply(input page_request_type rq);
      frame_reply_type rp;
      int unsigned cnt, lo, hi;
      logic [CFG_W-1:0] top;
      bit on_list;
      rp = '0;
      cnt = managed_pages();
      case (rq.cmd)
         CMD_INIT: begin
            lo = (cfg_base < cnt) ? cfg_base : cnt;
            hi = (cfg_first < cnt) ? cfg_first : cnt;
            if (hi < lo)
               hi = lo;
            head_pg = NIL_PAGE;
            tail_pg = NIL_PAGE;
            held_pages.delete();
            for (int i = 0; i < PAGE_SPAN; i++) begin
               on_list = (i >= 1 && i < lo) || (i >= hi && i < cnt);
               link_tbl[i] = NIL_PAGE;
               listed_tbl[i] = on_list;
               refs_tbl[i] = on_list ? '0 : REF_BITS'(1);
               if (on_list) begin
                  if (tail_pg == NIL_PAGE)
                     head_pg = CFG_W'(i);
                  else
                     link_tbl[tail_pg] = CFG_W'(i);
                  tail_pg = CFG_W'(i);
               end
            end
            rebuilds_seen++;
         end
         CMD_ALLOC: begin
            if (head_pg == NIL_PAGE) begin
               rp.status = STS_NO_MEMORY;
            end else begin
               top = head_pg;
               head_pg = link_tbl[top];
               link_tbl[top] = NIL_PAGE;
               listed_tbl[top] = 1'b0;
               if (head_pg == NIL_PAGE)
                  tail_pg = NIL_PAGE;
               rp.granted = top[PAGE_W-1:0];
               rp.clear = rq.zf;
               held_pages.push_back(top[PAGE_W-1:0]);
            end
         end
         CMD_FREE: begin
            if (rq.page >= cnt)
               rp.status = STS_RANGE;
            else
               rp.status = push_free_page(rq.page);
         end
         CMD_DECREF: begin
            if (rq.page >= cnt) begin
               rp.status = STS_RANGE;
            end else if (refs_tbl[rq.page] == 0) begin
               rp.status = STS_UNDERFLOW;
            end else begin
               refs_tbl[rq.page] = refs_tbl[rq.page] - 1'b1;
               if (refs_tbl[rq.page] == 0) begin
                  rp.status = push_free_page(rq.page);
                  rp.freed = (rp.status == STS_OK);
               end
            end
         end
         CMD_QUERY: begin
            if (rq.page >= cnt)
               rp.status = STS_RANGE;
            else
               rp.alloc = !listed_tbl[rq.page];
         end
         default: ;
      endcase
      return rp;
   endfunction

   task automatic flag_field(input string fld, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
      end
   endtask

   // request acceptance and response checking
   always @(posedge clock) begin
      frame_reply_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_replies.push_back(
               predict_frame_reply({req_command, req_page_index, req_zero_fill}));
            requests_sent++;
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            replies_checked++;
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response, expected none, actual status %0d page %0d",
                        $time, rsp_status, rsp_granted_page);
            end else begin
               want = expected_replies.pop_front();
               flag_field("status", want.status, rsp_status);
               flag_field("granted_page", want.granted, rsp_granted_page);
               flag_field("is_allocated", want.alloc, rsp_is_allocated);
               flag_field("clear_request", want.clear, rsp_clear_request);
               flag_field("page_freed", want.freed, rsp_page_freed);
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_busy && req_taken) begin
            req_busy = 1'b0;
            req_gap = gaps_on ? $urandom_range(0, 5) : 0;
         end
         req_taken = 1'b0;
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (cmd_backlog.size() > 0) begin
               cur_req = cmd_backlog.pop_front();
               req_busy = 1'b1;
            end
         end
      end
      req_valid      <= req_busy;
      req_command    <= cur_req.cmd;
      req_page_index <= cur_req.page;
      req_zero_fill  <= cur_req.zf;
   end

   // response side back-pressure
   always @(negedge clock) begin
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_left = 60;
      end
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         rsp_wait = gaps_on ? $urandom_range(0, 5) : 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send(input logic [CMD_W-1:0] c, input logic [PAGE_W-1:0] p, input logic z);
      while (cmd_backlog.size() >= 4)
         @(negedge clock);
      cmd_backlog.push_back({c, p, z});
   endtask

   task automatic wait_idle();
      while (cmd_backlog.size() != 0 || req_busy || expected_replies.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_TOTAL_PAGES: cfg_total = val;
         CSR_BASE_PAGES:  cfg_base = val;
         CSR_FIRST_FREE:  cfg_first = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int t, input int b, input int f);
      wait_idle();
      write_reg(CSR_TOTAL_PAGES, CFG_W'(t));
      write_reg(CSR_BASE_PAGES, CFG_W'(b));
      write_reg(CSR_FIRST_FREE, CFG_W'(f));
      settings_used++;
      send(CMD_INIT, PAGE_W'($urandom), 1'($urandom));
   endtask

   function automatic logic [PAGE_W-1:0] any_page();
      int unsigned cnt;
      cnt = managed_pages();
      if (cnt == 0 || $urandom_range(0, 6) == 0)
         return PAGE_W'($urandom_range(0, PAGE_MAX_IDX));
      return PAGE_W'($urandom_range(0, cnt - 1));
   endfunction

   initial begin
      int t, b, f, r, a, idx;
      logic [PAGE_W-1:0] pg;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default layout
      send(CMD_ALLOC, 0, 1'b1);
      send(CMD_INIT, 0, 1'b0);
      send(CMD_UNUSED_LAST, PAGE_W'(PAGE_MAX_IDX), 1'b1);
      send(CMD_ALLOC, 0, 1'b1);
      send(CMD_ALLOC, PAGE_W'(PAGE_MAX_IDX), 1'b0);
      send(CMD_QUERY, 1, 1'b0);
      send(CMD_QUERY, 3, 1'b0);
      send(CMD_QUERY, 0, 1'b0);
      send(CMD_FREE, 1, 1'b0);
      send(CMD_FREE, 1, 1'b0);
      send(CMD_FREE, 0, 1'b0);
      send(CMD_DECREF, 0, 1'b0);
      send(CMD_DECREF, 0, 1'b0);
      send(CMD_DECREF, 500, 1'b0);
      send(CMD_DECREF, 2, 1'b0);
      send(CMD_ALLOC, 0, 1'b0);
      send(CMD_QUERY, PAGE_W'(PAGE_MAX_IDX), 1'b0);

      // directed: smallest layout, one free page
      configure(2, 1, 1);
      send(CMD_ALLOC, 0, 1'b1);
      send(CMD_ALLOC, 0, 1'b1);
      send(CMD_QUERY, 2, 1'b0);
      send(CMD_FREE, PAGE_W'(PAGE_MAX_IDX), 1'b1);
      send(CMD_FREE, 1, 1'b0);
      send(CMD_DECREF, 1, 1'b0);

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin t = 8191; b = 8191; f = 8191; end
            1: begin t = 0; b = 0; f = 0; end
            2: begin t = PAGE_SPAN; b = 1; f = PAGE_SPAN; end
            3: begin t = 24; b = 20; f = 10; end
            4: begin
               t = PAGE_SPAN;
               b = $urandom_range(0, PAGE_SPAN);
               f = $urandom_range(0, 8191);
            end
            default: begin
               t = $urandom_range(2, 48);
               b = $urandom_range(0, t + 3);
               f = $urandom_range(0, t + 3);
            end
         endcase
         configure(t, b, f);
         gaps_on = (ph % 3) != 2;
         a = $urandom_range(20, 45);
         for (int n = 0; n < 55; n++) begin
            if ((ph == 3 || ph == 6) && n == 8)
               hold_off_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < a) begin
               send(CMD_ALLOC, PAGE_W'($urandom), 1'($urandom));
            end else if (r < a + 25) begin
               if (held_pages.size() > 0 && $urandom_range(0, 3) != 0) begin
                  idx = $urandom_range(0, held_pages.size() - 1);
                  pg = held_pages[idx];
                  held_pages.delete(idx);
               end else begin
                  pg = any_page();
               end
               send(CMD_FREE, pg, 1'($urandom));
            end else if (r < a + 37) begin
               if (held_pages.size() > 0 && $urandom_range(0, 1) != 0)
                  pg = held_pages[$urandom_range(0, held_pages.size() - 1)];
               else
                  pg = any_page();
               send(CMD_DECREF, pg, 1'($urandom));
            end else if (r < a + 47) begin
               send(CMD_QUERY, any_page(), 1'($urandom));
            end else if (r < a + 49) begin
               send(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                    PAGE_W'($urandom), 1'($urandom));
            end else if (r == 99) begin
               send(CMD_INIT, PAGE_W'($urandom), 1'($urandom));
            end else begin
               case ($urandom_range(0, 2))
                  0: send(CMD_FREE, PAGE_W'($urandom), 1'($urandom));
                  1: send(CMD_DECREF, PAGE_W'($urandom), 1'($urandom));
                  default: send(CMD_QUERY, PAGE_W'($urandom), 1'($urandom));
               endcase
            end
         end
      end

      wait_idle();
      repeat (20) @(negedge clock);
      $display("%0d requests sent, %0d responses checked, %0d mismatches",
               requests_sent, replies_checked, mismatch_count);
      $display("%0d free list rebuilds over %0d register settings, with long response hold-offs",
               rebuilds_seen, settings_used);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout, %0d responses still outstanding", $time, expected_replies.size());
      $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire
